// ===== rtl/core/lrt_pkg.sv =====
// ----------------------------------------------------------------------------
// lrt_pkg
// Shared operation and status codes of the LRU replacement tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package lrt_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned STATUS_W = 2;

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Request operations.
  localparam func_t FUNC_INSERT = 2'd0;
  localparam func_t FUNC_VICTIM = 2'd1;
  localparam func_t FUNC_ERASE  = 2'd2;

  // Result status codes.
  localparam status_t ST_DONE = 2'd0;
  localparam status_t ST_MISS = 2'd1;
  localparam status_t ST_FULL = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/lrt_if.sv =====
// ----------------------------------------------------------------------------
// lrt_req_if / lrt_rsp_if
// Valid/ready channels carrying tracker requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrt_req_if
  import lrt_pkg::*;
#(
  parameter int unsigned KeyW = 16
);
  logic            valid;
  logic            ready;
  func_t           func;
  logic [KeyW-1:0] key;

  modport source (output valid, func, key, input ready);
  modport sink   (input valid, func, key, output ready);
endinterface

interface lrt_rsp_if
  import lrt_pkg::*;
#(
  parameter int unsigned KeyW   = 16,
  parameter int unsigned CountW = 5
);
  logic              valid;
  logic              ready;
  status_t           status;
  logic              hit;
  logic [KeyW-1:0]   victim_key;
  logic [CountW-1:0] entry_count;

  modport source (output valid, status, hit, victim_key, entry_count, input ready);
  modport sink   (input valid, status, hit, victim_key, entry_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lrt_mem.sv =====
// ----------------------------------------------------------------------------
// lrt_mem
// Simple dual-port key store: one write port, one read port with a
// registered read data output.
// ----------------------------------------------------------------------------
`default_nettype none

module lrt_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/lru_replacement_tracker.sv =====
// ----------------------------------------------------------------------------
// lru_replacement_tracker
// Least-recently-used replacement list of up to CAPACITY distinct keys.
// ----------------------------------------------------------------------------
// Keys are held in one memory in recency order, slot 0 least recent. Each
// request makes a single pass over the held slots: the read port walks the
// slots in order while the write port, one slot behind, moves every slot past
// the removed key down by one. The walk covers one slot per cycle, so a result
// takes longer the more keys are held; once it is loaded, the block returns to
// idle and takes the next request. A finished result waits in the output
// register while the next request is taken; only the end of that next pass
// waits for the register to drain.
// An insert of a new key into a full store is refused with the full status.
`default_nettype none

module lru_replacement_tracker
  import lrt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned KEY_BITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lrt_req_if.sink    req_i,
  lrt_rsp_if.source  rsp_o
);

  localparam int unsigned CountW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW   = $clog2(CAPACITY);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  logic [CountW-1:0]   idx_q, idx_d;
  logic [CountW-1:0]   pslot_q, pslot_d;
  logic                pend_q, pend_d;
  logic                found_q, found_d;
  func_t               func_q, func_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [KEY_BITS-1:0] vkey_q, vkey_d;

  logic                out_valid_q, out_valid_d;
  status_t             out_status_q, out_status_d;
  logic                out_hit_q, out_hit_d;
  logic [KEY_BITS-1:0] out_victim_q, out_victim_d;
  logic [CountW-1:0]   out_count_q, out_count_d;

  logic                mem_we, mem_re;
  logic [IdxW-1:0]     mem_waddr, mem_raddr;
  logic [KEY_BITS-1:0] mem_wdata, mem_rdata;

  logic                load_out;
  logic                match;
  logic [CountW-1:0]   slot_m1;
  logic [CountW-1:0]   cnt_m1;

  lrt_mem #(
    .Depth (CAPACITY),
    .Width (KEY_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign load_out    = (state_q == S_FINISH) && (!out_valid_q || rsp_o.ready);
  assign slot_m1     = pslot_q - CountW'(1);
  assign cnt_m1      = cnt_q - CountW'(1);

  // A victim request removes slot 0; insert and erase remove the first match.
  always_comb begin
    match = 1'b0;
    if (pend_q && !found_q) begin
      case (func_q) inside
        FUNC_INSERT, FUNC_ERASE: match = (mem_rdata == key_q);
        FUNC_VICTIM:             match = (pslot_q == '0);
        default:                 match = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    pslot_d   = pslot_q;
    pend_d    = 1'b0;
    found_d   = found_q;
    func_d    = func_q;
    key_d     = key_q;
    vkey_d    = vkey_q;
    mem_we    = 1'b0;
    mem_waddr = slot_m1[IdxW-1:0];
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = idx_q[IdxW-1:0];

    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_hit_d    = out_hit_q;
    out_victim_d = out_victim_q;
    out_count_d  = out_count_q;
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          func_d  = req_i.func;
          key_d   = req_i.key;
          vkey_d  = '0;
          found_d = 1'b0;
          idx_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_q < cnt_q) begin
          mem_re  = 1'b1;
          pend_d  = 1'b1;
          pslot_d = idx_q;
          idx_d   = idx_q + CountW'(1);
        end
        // Slots after the removed one shift down by one as they stream by.
        if (pend_q && found_q) begin
          mem_we = 1'b1;
        end
        if (match) begin
          found_d = 1'b1;
          if (func_q == FUNC_VICTIM) begin
            vkey_d = mem_rdata;
          end
        end
        if (!pend_q && (idx_q == cnt_q)) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (load_out) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_MISS;
          out_hit_d    = 1'b0;
          out_victim_d = '0;
          out_count_d  = cnt_q;
          case (func_q)
            FUNC_INSERT: begin
              mem_wdata = key_q;
              if (found_q) begin
                // The held key was closed up; it goes back in on top.
                mem_we       = 1'b1;
                mem_waddr    = cnt_m1[IdxW-1:0];
                out_status_d = ST_DONE;
                out_hit_d    = 1'b1;
              end else if (cnt_q == CountW'(CAPACITY)) begin
                out_status_d = ST_FULL;
              end else begin
                mem_we       = 1'b1;
                mem_waddr    = cnt_q[IdxW-1:0];
                cnt_d        = cnt_q + CountW'(1);
                out_count_d  = cnt_q + CountW'(1);
                out_status_d = ST_DONE;
              end
            end
            FUNC_VICTIM: begin
              if (found_q) begin
                cnt_d        = cnt_m1;
                out_count_d  = cnt_m1;
                out_status_d = ST_DONE;
                out_victim_d = vkey_q;
              end
            end
            FUNC_ERASE: begin
              if (found_q) begin
                cnt_d        = cnt_m1;
                out_count_d  = cnt_m1;
                out_status_d = ST_DONE;
                out_hit_d    = 1'b1;
              end
            end
            default: ;
          endcase
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pslot_q      <= pslot_d;
    func_q       <= func_d;
    key_q        <= key_d;
    vkey_q       <= vkey_d;
    out_status_q <= out_status_d;
    out_hit_q    <= out_hit_d;
    out_victim_q <= out_victim_d;
    out_count_q  <= out_count_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.hit         = out_hit_q;
  assign rsp_o.victim_key  = out_victim_q;
  assign rsp_o.entry_count = out_count_q;

endmodule

`default_nettype wire

// ===== dv/lru_replacement_tracker_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_replacement_tracker_test
// Self-checking test of the LRU replacement tracker. A scoreboard keeps its
// own recency list, predicts one result per accepted request and compares
// every result field by field, under three idling patterns.
// ----------------------------------------------------------------------------

module lru_replacement_tracker_test
  import lrt_pkg::*;
();

  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned KEY_BITS     = 16;
  localparam int unsigned COUNT_W      = 5;
  localparam int unsigned PHASE_ITEMS  = 290;
  localparam int unsigned POOL_SIZE    = 20;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned REPORT_LIMIT = 10;

  // The operation code the block does not define; it must leave the store unchanged and give the miss status.
  localparam func_t FUNC_UNUSED = 2'd3;

  typedef logic [KEY_BITS-1:0] key_t;

  typedef struct packed {
    status_t              status;
    logic                 hit;
    key_t                 victim_key;
    logic [COUNT_W-1:0]   entry_count;
  } lru_result_t;

  class recency_scoreboard;
    key_t        held_keys[$];        // Index 0 is the least recent key.
    lru_result_t pending_results[$];
    int unsigned mismatches;
    int unsigned hits;
    int unsigned refusals;
    int unsigned evictions;
    int unsigned misses;

    function void apply_request(func_t op, key_t key);
      lru_result_t res;
      int          pos;
      res = lru_result_t'{status: ST_MISS, hit: 1'b0, victim_key: '0, entry_count: '0};
      pos = -1;
      foreach (held_keys[i]) begin
        if (pos < 0 && held_keys[i] == key) pos = i;
      end
      case (op)
        FUNC_INSERT: begin
          if (pos >= 0) begin
            held_keys.delete(pos);
            held_keys.push_back(key);
            res.status = ST_DONE;
            res.hit    = 1'b1;
          end else if (held_keys.size() >= CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            held_keys.push_back(key);
            res.status = ST_DONE;
          end
        end
        FUNC_VICTIM: begin
          if (held_keys.size() > 0) begin
            res.victim_key = held_keys.pop_front();
            res.status     = ST_DONE;
            evictions++;
          end
        end
        FUNC_ERASE: begin
          if (pos >= 0) begin
            held_keys.delete(pos);
            res.status = ST_DONE;
            res.hit    = 1'b1;
          end
        end
        default: begin
        end
      endcase
      res.entry_count = COUNT_W'(held_keys.size());
      if (res.hit) hits++;
      if (res.status == ST_FULL) refusals++;
      if (res.status == ST_MISS) misses++;
      pending_results.push_back(res);
    endfunction

    function void check_result(lru_result_t got);
      lru_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: result with no request outstanding: status %0d hit %0d victim %h count %0d",
                   $realtime, got.status, got.hit, got.victim_key, got.entry_count);
        end
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.hit !== want.hit ||
          got.victim_key !== want.victim_key || got.entry_count !== want.entry_count) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: result mismatch: status %0d/%0d hit %0d/%0d victim %h/%h count %0d/%0d",
                   $realtime, got.status, want.status, got.hit, want.hit,
                   got.victim_key, want.victim_key, got.entry_count, want.entry_count);
          $display("  (values are actual/expected)");
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  lrt_req_if #(.KeyW(KEY_BITS))                   req_if ();
  lrt_rsp_if #(.KeyW(KEY_BITS), .CountW(COUNT_W)) rsp_if ();

  lru_replacement_tracker #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  recency_scoreboard sb;
  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;
  int unsigned       stall_cycles;
  int unsigned       requests_taken;
  key_t              key_pool[POOL_SIZE];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The receiver stalls at random, one decision per cycle.
  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Both transfer monitors sample the values that held at the clock edge.
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      sb.apply_request(req_if.func, req_if.key);
      requests_taken++;
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      sb.check_result(lru_result_t'{status: rsp_if.status, hit: rsp_if.hit,
                                    victim_key: rsp_if.victim_key,
                                    entry_count: rsp_if.entry_count});
    end
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("No transfer for %0d cycles, giving up.", STALL_LIMIT);
    $display("lru_replacement_tracker_test: errors");
    $finish;
  end

  task automatic send_request(input func_t op, input key_t key);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.func  <= op;
    req_if.key   <= key;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic run_directed();
    send_request(FUNC_INSERT, 16'h0000);
    send_request(FUNC_INSERT, 16'hFFFF);
    send_request(FUNC_INSERT, 16'h0000);   // touch moves 0 behind FFFF
    send_request(FUNC_VICTIM, 16'h0000);
    send_request(FUNC_ERASE,  16'h0000);
    send_request(FUNC_VICTIM, 16'h5A5A);   // empty store
    send_request(FUNC_ERASE,  16'h1234);   // absent key
    send_request(FUNC_UNUSED, 16'hAAAA);
    for (int i = 0; i < CAPACITY; i++) send_request(FUNC_INSERT, key_t'(1) << i);
    send_request(FUNC_INSERT, 16'hA5A5);   // refused, store is full
    send_request(FUNC_INSERT, 16'h0008);   // touch while full
    send_request(FUNC_ERASE,  16'h8000);
    send_request(FUNC_VICTIM, 16'h0000);
  endtask

  // Segments with shifting operation mix, keys mostly from a small pool so
  // that hits, a full store and an empty store all recur.
  task automatic run_random(input int unsigned count);
    int unsigned insert_pct;
    int unsigned roll;
    func_t       op;
    key_t        key;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) insert_pct = $urandom_range(30, 85);
      roll = $urandom_range(99);
      if (roll < insert_pct) begin
        op = FUNC_INSERT;
      end else if (roll == 99) begin
        op = FUNC_UNUSED;
      end else if (roll < insert_pct + (100 - insert_pct) / 2) begin
        op = FUNC_VICTIM;
      end else begin
        op = FUNC_ERASE;
      end
      if ($urandom_range(99) < 85) begin
        key = key_pool[$urandom_range(POOL_SIZE - 1)];
      end else begin
        key = key_t'($urandom);
      end
      send_request(op, key);
    end
  endtask

  initial begin
    sb             = new();
    stall_cycles   = 0;
    requests_taken = 0;
    send_idle_pct  = 16;
    recv_idle_pct  = 46;
    req_if.valid   = 1'b0;
    req_if.func    = FUNC_INSERT;
    req_if.key     = '0;
    rsp_if.ready   = 1'b0;
    rst_ni         = 1'b0;
    key_pool[0]    = '0;
    key_pool[1]    = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = key_t'($urandom);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random(PHASE_ITEMS);
    send_idle_pct = 46;
    recv_idle_pct = 16;
    run_random(PHASE_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(PHASE_ITEMS);
    req_if.valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (CAPACITY + 8) @(posedge clk_i);

    $display("Ran %0d requests: %0d hits, %0d evictions, %0d refused on a full store,",
             requests_taken, sb.hits, sb.evictions, sb.refusals);
    $display("%0d misses; %0d mismatching results.", sb.misses, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("lru_replacement_tracker_test: clean");
    end else begin
      $display("lru_replacement_tracker_test: errors");
    end
    $finish;
  end

endmodule

// ===== lru_replacement_tracker.f =====
rtl/core/lrt_pkg.sv
rtl/core/lrt_if.sv
rtl/core/lrt_mem.sv
rtl/core/lru_replacement_tracker.sv
dv/lru_replacement_tracker_test.sv
